// File: sv/assert_macros.svh
// Assertion macros used by the quaternion to Euler angle queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");
`define QTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define QTE_ASSERT(lbl, clk, rst_n, prop)
`define QTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/qte_pkg.sv
// Types, constants and helper functions for the quaternion to Euler angle block.
package qte_pkg;

    localparam int TW        = 34;
    localparam int T2W       = 30;
    localparam int RADW      = 58;
    localparam int ROOTW     = 29;
    localparam int SQ_STAGES = 29;
    localparam int CW        = 36;
    localparam int ANGW      = 25;
    localparam int MAX_STEPS = 24;
    localparam int QDEPTH    = 4;
    localparam int QAW       = 2;
    localparam int QCW       = 3;

    localparam logic signed [TW-1:0]   ONE_Q28   = 34'sd268435456;
    localparam logic signed [TW-1:0]   NEG_Q28   = -34'sd268435456;
    localparam logic signed [ANGW-1:0] DEG90     = 25'sd5898240;
    localparam logic signed [ANGW-1:0] ROUND_OFS = 25'sd512;
    localparam logic signed [14:0]     ROLL_LIM  = 15'sd11520;
    localparam logic signed [14:0]     PITCH_LIM = 15'sd5760;

    typedef struct packed {
        logic signed [TW-1:0]  t0;
        logic signed [TW-1:0]  t1;
        logic signed [T2W-1:0] t2;
        logic signed [TW-1:0]  t3;
        logic signed [TW-1:0]  t4;
        logic [RADW-1:0]       rad;
    } t_terms;

    // atan(2^-i) in degrees times 2^16, rounded to nearest.
    function automatic logic signed [ANGW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ANGW-1:0] v;
        begin
            case (idx)
                5'd0:  v = 25'sd2949120;
                5'd1:  v = 25'sd1740967;
                5'd2:  v = 25'sd919879;
                5'd3:  v = 25'sd466945;
                5'd4:  v = 25'sd234379;
                5'd5:  v = 25'sd117304;
                5'd6:  v = 25'sd58666;
                5'd7:  v = 25'sd29335;
                5'd8:  v = 25'sd14668;
                5'd9:  v = 25'sd7334;
                5'd10: v = 25'sd3667;
                5'd11: v = 25'sd1833;
                5'd12: v = 25'sd917;
                5'd13: v = 25'sd458;
                5'd14: v = 25'sd229;
                5'd15: v = 25'sd115;
                5'd16: v = 25'sd57;
                5'd17: v = 25'sd29;
                5'd18: v = 25'sd14;
                5'd19: v = 25'sd7;
                5'd20: v = 25'sd4;
                5'd21: v = 25'sd2;
                5'd22: v = 25'sd1;
                default: v = 25'sd0;
            endcase
            return v;
        end
    endfunction

    // Round the angle to 64 counts per degree and saturate to +-lim.
    function automatic logic signed [14:0] to_counts(input logic signed [ANGW-1:0] z,
                                                     input logic signed [14:0] lim);
        logic signed [ANGW-1:0] c;
        logic signed [ANGW-1:0] l;
        begin
            c = (z + ROUND_OFS) >>> 10;
            l = ANGW'(lim);
            if (c > l) begin
                c = l;
            end else if (c < -l) begin
                c = -l;
            end
            return 15'(c);
        end
    endfunction

endpackage

// File: sv/qte_front.sv
// Front part: forms the exact Q28 terms and the square root radicand.
module qte_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [15:0]     i_w,
    input  logic signed [15:0]     i_x,
    input  logic signed [15:0]     i_y,
    input  logic signed [15:0]     i_z,
    input  logic                   i_full,
    output logic                   o_push,
    output qte_pkg::t_terms        o_terms
);

    logic r_v1, r_v2, r_v3;
    logic en;

    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_xz, r_wz, r_xy, r_zz;
    logic signed [qte_pkg::TW-1:0]  r_t0, r_t1, r_t3, r_t4;
    logic signed [qte_pkg::T2W-1:0] r_t2;
    logic signed [qte_pkg::TW-1:0]  n_t0, n_t1, n_t2r, n_t3, n_t4;
    logic signed [qte_pkg::T2W-1:0] n_t2;
    logic [qte_pkg::ROOTW-1:0]      n_mag;
    logic [qte_pkg::RADW-1:0]       n_sq;
    qte_pkg::t_terms                r_out;

    assign en      = !(r_v3 && i_full);
    assign o_ready = en;
    assign o_push  = r_v3 && !i_full;
    assign o_terms = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        n_t0  = (qte_pkg::TW'(r_wx) + qte_pkg::TW'(r_yz)) <<< 1;
        n_t1  = qte_pkg::ONE_Q28 - ((qte_pkg::TW'(r_xx) + qte_pkg::TW'(r_yy)) <<< 1);
        n_t2r = (qte_pkg::TW'(r_wy) - qte_pkg::TW'(r_xz)) <<< 1;
        n_t3  = (qte_pkg::TW'(r_wz) + qte_pkg::TW'(r_xy)) <<< 1;
        n_t4  = qte_pkg::ONE_Q28 - ((qte_pkg::TW'(r_yy) + qte_pkg::TW'(r_zz)) <<< 1);
        if (n_t2r > qte_pkg::ONE_Q28) begin
            n_t2 = qte_pkg::T2W'(qte_pkg::ONE_Q28);
        end else if (n_t2r < qte_pkg::NEG_Q28) begin
            n_t2 = qte_pkg::T2W'(qte_pkg::NEG_Q28);
        end else begin
            n_t2 = qte_pkg::T2W'(n_t2r);
        end
    end

    always_comb begin
        n_mag = r_t2[qte_pkg::T2W-1] ? qte_pkg::ROOTW'(-r_t2) : qte_pkg::ROOTW'(r_t2);
        n_sq  = qte_pkg::RADW'(n_mag) * qte_pkg::RADW'(n_mag);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= i_w * i_x;
            r_yz <= i_y * i_z;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_wy <= i_w * i_y;
            r_xz <= i_x * i_z;
            r_wz <= i_w * i_z;
            r_xy <= i_x * i_y;
            r_zz <= i_z * i_z;
            r_t0 <= n_t0;
            r_t1 <= n_t1;
            r_t2 <= n_t2;
            r_t3 <= n_t3;
            r_t4 <= n_t4;
            r_out.t0  <= r_t0;
            r_out.t1  <= r_t1;
            r_out.t2  <= r_t2;
            r_out.t3  <= r_t3;
            r_out.t4  <= r_t4;
            r_out.rad <= (qte_pkg::RADW'(1) << 56) - n_sq;
        end
    end

endmodule

// File: sv/qte_queue.sv
// Short queue of term sets between the front and back parts.
`include "assert_macros.svh"
module qte_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qte_pkg::t_terms i_data,
    output logic            o_full,
    output logic            o_valid,
    output qte_pkg::t_terms o_data,
    input  logic            i_pop
);

    qte_pkg::t_terms           r_mem [qte_pkg::QDEPTH];
    logic [qte_pkg::QAW-1:0]   r_wr, r_rd;
    logic [qte_pkg::QCW-1:0]   r_cnt;

    assign o_full  = (r_cnt == qte_pkg::QCW'(qte_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `QTE_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full))
    `QTE_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && !o_valid))
    `QTE_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= qte_pkg::QCW'(qte_pkg::QDEPTH))
    `QTE_ASSERT_NEXT(a_cnt_inc, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1)

endmodule

// File: sv/qte_cordic.sv
// Pipelined vectoring CORDIC that returns atan2(y, x) in degrees times 2^16.
module qte_cordic #(
    parameter int STEPS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [qte_pkg::CW-1:0]  i_y,
    input  logic signed [qte_pkg::CW-1:0]  i_x,
    output logic signed [qte_pkg::ANGW-1:0] o_ang
);

    logic signed [qte_pkg::CW-1:0]   r_x [STEPS+1];
    logic signed [qte_pkg::CW-1:0]   r_y [STEPS+1];
    logic signed [qte_pkg::ANGW-1:0] r_z [STEPS+1];

    // A vector in the left half plane is first turned by a quarter turn.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    r_x[0] <= i_y;
                    r_y[0] <= -i_x;
                    r_z[0] <= qte_pkg::DEG90;
                end else begin
                    r_x[0] <= -i_y;
                    r_y[0] <= i_x;
                    r_z[0] <= -qte_pkg::DEG90;
                end
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic signed [qte_pkg::ANGW-1:0] ang;
        assign ang = qte_pkg::atan_entry(5'(g));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[g] > 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + ang;
                end else if (r_y[g] < 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - ang;
                end else begin
                    r_x[g+1] <= r_x[g];
                    r_y[g+1] <= r_y[g];
                    r_z[g+1] <= r_z[g];
                end
            end
        end
    end

    assign o_ang = r_z[STEPS];

endmodule

// File: sv/qte_back.sv
// Back part: square root for pitch, three CORDIC pipelines and the output register.
module qte_back #(
    parameter int STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  qte_pkg::t_terms    i_terms,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [14:0] o_roll,
    output logic signed [13:0] o_pitch,
    output logic signed [14:0] o_yaw
);

    localparam int NS = qte_pkg::SQ_STAGES;

    logic en;
    logic r_ov;
    logic signed [14:0] r_roll, r_yaw;
    logic signed [13:0] r_pitch;

    logic                           r_sv   [NS+1];
    logic [30:0]                    r_rem  [NS+1];
    logic [qte_pkg::ROOTW-1:0]      r_root [NS+1];
    logic [qte_pkg::RADW-1:0]       r_rad  [NS+1];
    logic signed [qte_pkg::TW-1:0]  r_t0 [NS+1];
    logic signed [qte_pkg::TW-1:0]  r_t1 [NS+1];
    logic signed [qte_pkg::T2W-1:0] r_t2 [NS+1];
    logic signed [qte_pkg::TW-1:0]  r_t3 [NS+1];
    logic signed [qte_pkg::TW-1:0]  r_t4 [NS+1];
    logic                           r_cv [STEPS+1];

    logic signed [qte_pkg::ANGW-1:0] roll_ang, pitch_ang, yaw_ang;
    logic signed [qte_pkg::CW-1:0]   pitch_x;

    // The whole back pipeline holds while the output register is stalled.
    assign en      = !(r_ov && !i_ready);
    assign o_pop   = en && i_valid;
    assign o_valid = r_ov;
    assign o_roll  = r_roll;
    assign o_pitch = r_pitch;
    assign o_yaw   = r_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_rad[0]  <= i_terms.rad;
            r_t0[0]   <= i_terms.t0;
            r_t1[0]   <= i_terms.t1;
            r_t2[0]   <= i_terms.t2;
            r_t3[0]   <= i_terms.t3;
            r_t4[0]   <= i_terms.t4;
        end
    end

    // One result bit of the restoring square root per stage.
    for (genvar j = 0; j < NS; j++) begin : g_sq
        logic [32:0] rn;
        logic [30:0] tr;
        logic        ge;
        always_comb begin
            rn = {r_rem[j], r_rad[j][qte_pkg::RADW-1 -: 2]};
            tr = {r_root[j], 2'b01};
            ge = (rn >= 33'(tr));
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j+1] <= 1'b0;
            end else if (en) begin
                r_sv[j+1] <= r_sv[j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[j+1]  <= ge ? 31'(rn - 33'(tr)) : 31'(rn);
                r_root[j+1] <= {r_root[j][qte_pkg::ROOTW-2:0], ge};
                r_rad[j+1]  <= r_rad[j] << 2;
                r_t0[j+1]   <= r_t0[j];
                r_t1[j+1]   <= r_t1[j];
                r_t2[j+1]   <= r_t2[j];
                r_t3[j+1]   <= r_t3[j];
                r_t4[j+1]   <= r_t4[j];
            end
        end
    end

    assign pitch_x = qte_pkg::CW'($signed({1'b0, r_root[NS]}));

    qte_cordic #(.STEPS(STEPS)) u_roll (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (qte_pkg::CW'(r_t0[NS])),
        .i_x   (qte_pkg::CW'(r_t1[NS])),
        .o_ang (roll_ang)
    );

    qte_cordic #(.STEPS(STEPS)) u_pitch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (qte_pkg::CW'(r_t2[NS])),
        .i_x   (pitch_x),
        .o_ang (pitch_ang)
    );

    qte_cordic #(.STEPS(STEPS)) u_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (qte_pkg::CW'(r_t3[NS])),
        .i_x   (qte_pkg::CW'(r_t4[NS])),
        .o_ang (yaw_ang)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= r_sv[NS];
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_cv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[k+1] <= 1'b0;
            end else if (en) begin
                r_cv[k+1] <= r_cv[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_cv[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll  <= qte_pkg::to_counts(roll_ang, qte_pkg::ROLL_LIM);
            r_pitch <= 14'(qte_pkg::to_counts(pitch_ang, qte_pkg::PITCH_LIM));
            r_yaw   <= qte_pkg::to_counts(yaw_ang, qte_pkg::ROLL_LIM);
        end
    end

endmodule

// File: sv/quaternion_to_euler_degrees.sv
// Quaternion to ZYX Euler angles in degrees, 64 counts per degree.
// From input request to result the path runs through three front stages, the queue, the square
// root stages and the CORDIC pipelines, whose step count is CORDIC_STEPS capped at MAX_STEPS.
// Throughput is one request per cycle unless the output stalls; the unrolled stages set it.
// Reset is synchronous, active low, and clears all valid bits and the queue; data is not reset.
module quaternion_to_euler_degrees #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // roll_deg, pitch_deg, yaw_deg, zero pad
);

    localparam int STEPS = (CORDIC_STEPS < qte_pkg::MAX_STEPS) ?
                           CORDIC_STEPS : qte_pkg::MAX_STEPS;

    logic            push, full, q_valid, pop;
    qte_pkg::t_terms f_terms, q_terms;
    logic signed [14:0] roll, yaw;
    logic signed [13:0] pitch;

    qte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_w     (s_axis_tdata[15:0]),
        .i_x     (s_axis_tdata[31:16]),
        .i_y     (s_axis_tdata[47:32]),
        .i_z     (s_axis_tdata[63:48]),
        .i_full  (full),
        .o_push  (push),
        .o_terms (f_terms)
    );

    qte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_terms),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_terms),
        .i_pop   (pop)
    );

    qte_back #(.STEPS(STEPS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_terms (q_terms),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_roll  (roll),
        .o_pitch (pitch),
        .o_yaw   (yaw)
    );

    assign m_axis_tdata = {4'b0000, yaw, pitch, roll};

endmodule
